FILE: rtl/ils_pkg.sv
// ils_pkg: shared types and character codes for the integer literal scanner
// holds the scan phase, result kind and status codes and the step structs
// no dependencies
package ils_pkg;

   // width of the value field on the result channel
   localparam int VALUE_BITS = 64;

   // scan phase; codes outside the list act as idle
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SIGN   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_USUF   = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      K_INT   = 2'd0,
      K_LONG  = 2'd1,
      K_UINT  = 2'd2,
      K_ULONG = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_DIGIT   = 3'd1,
      ST_DIGIT_OVF  = 3'd2,
      ST_TOO_BIG    = 3'd3,
      ST_FRACTIONAL = 3'd4
   } status_type;

   // character codes
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_F_UP  = 8'h46;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_L_LO  = 8'h6C;
   localparam logic [7:0] CH_L_UP  = 8'h4C;
   localparam logic [7:0] CH_U_LO  = 8'h75;
   localparam logic [7:0] CH_U_UP  = 8'h55;
   localparam logic [7:0] CH_E_LO  = 8'h65;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   // scan state other than the accumulator
   typedef struct packed {
      phase_type phase;
      logic      negative;
      logic      hex_mode;
      logic      only_zeros;
   } scan_state_type;

   // one result of a step
   typedef struct packed {
      logic       emit;
      kind_type   kind;
      status_type status;
      logic       consumed;
   } step_result_type;

endpackage

FILE: rtl/integer_literal_scanner.sv
// integer_literal_scanner: top level of the C-style integer literal scanner
// input register, scan state registers and result register around ils_step
// depends on ils_pkg and ils_step
//
// Usage: characters arrive one per req transaction, req_tdata holding the
// character and req_tlast marking end of text (the character is then ignored).
// The scanner follows an optional sign, decimal or 0x-prefixed hex digits and
// an L, U or UL suffix. A result transaction on rsp gives the value, kind,
// status and whether the character that ended the literal was consumed; after
// every result the scanner is back in idle, ready for the next literal.
// Throughput is one character per cycle while no result is stalled: the step
// logic between the input register and the result register is combinational.
// An accepted character is held in the input register, and its result, if it
// gives one, is registered in the result register, which drives rsp_tvalid.
// Reset (synchronous, active high) empties both registers and returns the
// scan state to idle with a cleared accumulator. When the receiver holds
// rsp_tready low, a character waiting in the input register stays there and
// req_tready drops until the pending result is taken.
module integer_literal_scanner #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [7:0]  rsp_tuser    // [1:0] kind, [4:2] status, [5] stop_consumed, [7:6] zero
);

   logic                                 in_valid_ff;
   logic [7:0]                           in_ch_ff;
   logic                                 in_eot_ff;
   ils_pkg::scan_state_type              state_ff;
   ils_pkg::scan_state_type              state_in;
   logic [VALUE_WIDTH-1:0]               acc_ff;
   logic [VALUE_WIDTH-1:0]               acc_in;
   ils_pkg::step_result_type             step_res;
   logic [ils_pkg::VALUE_BITS-1:0]       step_value;
   logic                                 rsp_valid_ff;
   logic [ils_pkg::VALUE_BITS-1:0]       rsp_value_ff;
   ils_pkg::kind_type                    rsp_kind_ff;
   ils_pkg::status_type                  rsp_status_ff;
   logic                                 rsp_consumed_ff;
   logic                                 fire;

   // the held character steps when the result register can take a result
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_ch_ff  <= req_tdata;
         in_eot_ff <= req_tlast;
      end
   end

   ils_step #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_step (
      .cur_state  (state_ff),
      .cur_acc    (acc_ff),
      .ch         (in_ch_ff),
      .end_of_text(in_eot_ff),
      .next_state (state_in),
      .next_acc   (acc_in),
      .result     (step_res),
      .value      (step_value)
   );

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= ils_pkg::PH_IDLE;
         state_ff.negative   <= 1'b0;
         state_ff.hex_mode   <= 1'b0;
         state_ff.only_zeros <= 1'b0;
         acc_ff              <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && step_res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire && step_res.emit) begin
         rsp_value_ff    <= step_value;
         rsp_kind_ff     <= step_res.kind;
         rsp_status_ff   <= step_res.status;
         rsp_consumed_ff <= step_res.consumed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {2'b00, rsp_consumed_ff, rsp_status_ff, rsp_kind_ff};

`ifndef ASSERT_OFF
   // an error result never carries a value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff != ils_pkg::ST_OK) |-> (rsp_tdata == '0))
      else $error("error result with nonzero value");

   // a produced result leaves the scanner idle with a clear accumulator
   assert property (@(posedge clock) disable iff (reset)
      (fire && step_res.emit) |=> (state_ff.phase == ils_pkg::PH_IDLE && acc_ff == '0))
      else $error("scan state not cleared after result");

   // a stalled result keeps the waiting character in the input register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("character lost while result stalled");

   // hex mode only inside a literal's digits or suffix
   assert property (@(posedge clock) disable iff (reset)
      state_ff.hex_mode |->
         (state_ff.phase == ils_pkg::PH_DIGITS || state_ff.phase == ils_pkg::PH_USUF))
      else $error("hex mode outside digits");
`endif

endmodule

FILE: rtl/ils_step.sv
// ils_step: combinational step of the literal scanner for one character
// computes next scan state, accumulator and the optional result
// depends on ils_pkg
module ils_step #(
   parameter int VALUE_WIDTH = 64
) (
   input  ils_pkg::scan_state_type                cur_state,
   input  logic [VALUE_WIDTH-1:0]                 cur_acc,
   input  logic [7:0]                             ch,
   input  logic                                   end_of_text,
   output ils_pkg::scan_state_type                next_state,
   output logic [VALUE_WIDTH-1:0]                 next_acc,
   output ils_pkg::step_result_type               result,
   output logic [ils_pkg::VALUE_BITS-1:0]         value
);

   localparam logic [VALUE_WIDTH-1:0] ACC_ONES   = '1;
   localparam logic [VALUE_WIDTH-1:0] MAX_DIV10  = ACC_ONES / VALUE_WIDTH'(10);
   localparam logic [VALUE_WIDTH-1:0] MAX_DIV16  = ACC_ONES >> 4;

   logic                   is_dec;
   logic                   is_hex_lo;
   logic                   is_hex_up;
   logic                   digit_ok;
   logic [3:0]             dval;
   logic                   is_x;
   logic                   is_l;
   logic                   is_u;
   logic                   is_e;
   logic                   is_sign;
   logic [VALUE_WIDTH-1:0] acc_scaled;
   logic [VALUE_WIDTH:0]   acc_sum;
   logic                   mul_ovf;
   logic                   digit_ovf;
   logic                   fin;
   ils_pkg::kind_type      fin_kind;
   logic                   fin_consumed;
   ils_pkg::step_result_type plain_res;
   logic                   too_big;
   logic [VALUE_WIDTH-1:0] signed_acc;

   // character classes and digit value
   always_comb begin
      is_dec    = (ch >= ils_pkg::CH_0) && (ch <= ils_pkg::CH_9);
      is_hex_lo = (ch >= ils_pkg::CH_A_LO) && (ch <= ils_pkg::CH_F_LO);
      is_hex_up = (ch >= ils_pkg::CH_A_UP) && (ch <= ils_pkg::CH_F_UP);
      is_x      = (ch == ils_pkg::CH_X_LO) || (ch == ils_pkg::CH_X_UP);
      is_l      = (ch == ils_pkg::CH_L_LO) || (ch == ils_pkg::CH_L_UP);
      is_u      = (ch == ils_pkg::CH_U_LO) || (ch == ils_pkg::CH_U_UP);
      is_e      = (ch == ils_pkg::CH_E_LO) || (ch == ils_pkg::CH_E_UP);
      is_sign   = (ch == ils_pkg::CH_MINUS) || (ch == ils_pkg::CH_PLUS);
      digit_ok  = is_dec || (cur_state.hex_mode && (is_hex_lo || is_hex_up));
      // letters a..f and A..F both sit one above a multiple of 16
      if (is_dec) begin
         dval = ch[3:0];
      end else begin
         dval = ch[3:0] + 4'd9;
      end
   end

   // accumulate one digit, base 10 by shift and add, base 16 by shift
   always_comb begin
      if (cur_state.hex_mode) begin
         acc_scaled = cur_acc << 4;
         mul_ovf    = cur_acc > MAX_DIV16;
      end else begin
         acc_scaled = (cur_acc << 3) + (cur_acc << 1);
         mul_ovf    = cur_acc > MAX_DIV10;
      end
      acc_sum   = {1'b0, acc_scaled} + (VALUE_WIDTH + 1)'(dval);
      digit_ovf = mul_ovf || acc_sum[VALUE_WIDTH];
   end

   // next state
   always_comb begin
      next_state = cur_state;
      next_acc   = cur_acc;
      case (cur_state.phase)
         ils_pkg::PH_DIGITS: begin
            if (end_of_text) begin
               next_state.phase = ils_pkg::PH_IDLE;
            end else if (digit_ok) begin
               if (!digit_ovf) begin
                  next_acc              = acc_sum[VALUE_WIDTH-1:0];
                  next_state.only_zeros = cur_state.only_zeros && (dval == 4'd0);
               end else begin
                  next_state.phase = ils_pkg::PH_IDLE;
               end
            end else if (cur_state.only_zeros && !cur_state.hex_mode && is_x) begin
               next_state.hex_mode   = 1'b1;
               next_state.only_zeros = 1'b0;
            end else if (!(ch == ils_pkg::CH_DOT || (!cur_state.hex_mode && is_e)) &&
                         !is_l && is_u) begin
               next_state.phase = ils_pkg::PH_USUF;
            end else begin
               next_state.phase = ils_pkg::PH_IDLE;
            end
         end
         ils_pkg::PH_USUF: begin
            next_state.phase = ils_pkg::PH_IDLE;
         end
         default: begin
            if (end_of_text) begin
               next_state.phase = ils_pkg::PH_IDLE;
            end else if (cur_state.phase != ils_pkg::PH_SIGN && is_sign) begin
               next_state.phase    = ils_pkg::PH_SIGN;
               next_state.negative = (ch == ils_pkg::CH_MINUS);
            end else if (is_dec) begin
               next_state.phase      = ils_pkg::PH_DIGITS;
               next_state.hex_mode   = 1'b0;
               next_state.only_zeros = (dval == 4'd0);
               next_acc              = VALUE_WIDTH'(dval);
            end else begin
               next_state.phase = ils_pkg::PH_IDLE;
            end
         end
      endcase
      // every result returns the scanner to its reset state
      if (next_state.phase == ils_pkg::PH_IDLE) begin
         next_state.negative   = 1'b0;
         next_state.hex_mode   = 1'b0;
         next_state.only_zeros = 1'b0;
         next_acc              = '0;
      end
   end

   // result decode: fixed-status results and requests to finish the literal
   always_comb begin
      plain_res.emit     = 1'b0;
      plain_res.kind     = ils_pkg::K_INT;
      plain_res.status   = ils_pkg::ST_OK;
      plain_res.consumed = 1'b0;
      fin                = 1'b0;
      fin_kind           = ils_pkg::K_INT;
      fin_consumed       = 1'b0;
      case (cur_state.phase)
         ils_pkg::PH_DIGITS: begin
            if (end_of_text) begin
               fin = 1'b1;
            end else if (digit_ok) begin
               if (digit_ovf) begin
                  plain_res.emit   = 1'b1;
                  plain_res.status = ils_pkg::ST_DIGIT_OVF;
               end
            end else if (cur_state.only_zeros && !cur_state.hex_mode && is_x) begin
               plain_res.emit = 1'b0;
            end else if (ch == ils_pkg::CH_DOT || (!cur_state.hex_mode && is_e)) begin
               plain_res.emit     = 1'b1;
               plain_res.status   = ils_pkg::ST_FRACTIONAL;
               plain_res.consumed = 1'b1;
            end else if (is_l) begin
               fin          = 1'b1;
               fin_kind     = ils_pkg::K_LONG;
               fin_consumed = 1'b1;
            end else if (!is_u) begin
               fin = 1'b1;
            end
         end
         ils_pkg::PH_USUF: begin
            fin = 1'b1;
            if (!end_of_text && is_l) begin
               fin_kind     = ils_pkg::K_ULONG;
               fin_consumed = 1'b1;
            end else begin
               fin_kind = ils_pkg::K_UINT;
            end
         end
         default: begin
            if (end_of_text ||
                !((cur_state.phase != ils_pkg::PH_SIGN && is_sign) || is_dec)) begin
               plain_res.emit   = 1'b1;
               plain_res.status = ils_pkg::ST_NO_DIGIT;
            end
         end
      endcase
   end

   // finish: range check against the kind, then sign and mask
   always_comb begin
      case (fin_kind)
         ils_pkg::K_INT:  too_big = (cur_acc[VALUE_WIDTH-1:31] != '0);
         ils_pkg::K_LONG: too_big = cur_acc[VALUE_WIDTH-1];
         ils_pkg::K_UINT: too_big = (cur_acc > VALUE_WIDTH'(64'hFFFF_FFFF));
         default:         too_big = 1'b0;
      endcase
      if (cur_state.negative) begin
         signed_acc = '0 - cur_acc;
      end else begin
         signed_acc = cur_acc;
      end
      value = '0;
      if (fin) begin
         result.emit     = 1'b1;
         result.kind     = fin_kind;
         result.consumed = fin_consumed;
         if (too_big) begin
            result.status = ils_pkg::ST_TOO_BIG;
         end else begin
            result.status = ils_pkg::ST_OK;
            if (fin_kind == ils_pkg::K_INT || fin_kind == ils_pkg::K_UINT) begin
               value = ils_pkg::VALUE_BITS'(signed_acc[31:0]);
            end else begin
               value = ils_pkg::VALUE_BITS'(signed_acc);
            end
         end
      end else begin
         result = plain_res;
      end
   end

endmodule

FILE: tb/sv/integer_literal_scanner_checker.sv
`timescale 1ns / 100ps
// integer_literal_scanner_checker: watches both stream channels of the scanner,
// predicts each result from the accepted characters and compares field by field
// depends on ils_pkg for the phase, kind, status and character codes
module integer_literal_scanner_checker #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_text
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] value
   input  logic [7:0]  rsp_tuser,   // [1:0] kind, [4:2] status, [5] stop_consumed, [7:6] zero
   output int          fail_count,
   output int          pending_count
);

   localparam logic [63:0] LONG_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
   localparam logic [63:0] WORD_MASK = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [63:0]         value;
      ils_pkg::kind_type   kind;
      ils_pkg::status_type status;
      logic                consumed;
   } literal_result_type;

   // expected literal results, oldest first
   literal_result_type literal_q[$];
   literal_result_type want;

   // predicted scan state
   ils_pkg::phase_type scan_phase;
   logic               minus_seen;
   logic               hex_digits;
   logic               zeros_only;
   logic [63:0]        acc_value;

   int mismatches = 0;
   int results_seen = 0;

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] wanted);
      mismatches++;
      $display("mismatch in %s at result %0d: got %h, expected %h",
               field, results_seen, got, wanted);
   endtask

   task automatic clear_scan();
      scan_phase = ils_pkg::PH_IDLE;
      minus_seen = 1'b0;
      hex_digits = 1'b0;
      zeros_only = 1'b0;
      acc_value  = '0;
   endtask

   // every result returns the scanner to idle
   task automatic push_literal(input logic [63:0] v, input ils_pkg::kind_type k,
                               input ils_pkg::status_type s, input logic c);
      literal_q.push_back('{value: v, kind: k, status: s, consumed: c});
      clear_scan();
   endtask

   // range check against the kind, then negate within the kind's width
   task automatic close_literal(input ils_pkg::kind_type k, input logic c);
      logic [63:0] lim;
      logic [63:0] msk;
      logic [63:0] v;
      case (k)
         ils_pkg::K_INT: begin
            lim = 64'h7FFF_FFFF;
            msk = WORD_MASK;
         end
         ils_pkg::K_LONG: begin
            lim = LONG_MASK >> 1;
            msk = LONG_MASK;
         end
         ils_pkg::K_UINT: begin
            lim = WORD_MASK;
            msk = WORD_MASK;
         end
         default: begin
            lim = LONG_MASK;
            msk = LONG_MASK;
         end
      endcase
      if (acc_value > lim) begin
         push_literal('0, k, ils_pkg::ST_TOO_BIG, c);
      end else begin
         v = minus_seen ? (64'd0 - acc_value) : acc_value;
         push_literal(v & msk, k, ils_pkg::ST_OK, c);
      end
   endtask

   function automatic int digit_of(input logic [7:0] c, input logic hex);
      if (c >= ils_pkg::CH_0 && c <= ils_pkg::CH_9) return int'(c - ils_pkg::CH_0);
      if (hex && c >= ils_pkg::CH_A_LO && c <= ils_pkg::CH_F_LO)
         return int'(c - ils_pkg::CH_A_LO) + 10;
      if (hex && c >= ils_pkg::CH_A_UP && c <= ils_pkg::CH_F_UP)
         return int'(c - ils_pkg::CH_A_UP) + 10;
      return -1;
   endfunction

   function automatic logic is_l(input logic [7:0] c);
      return (c == ils_pkg::CH_L_LO) || (c == ils_pkg::CH_L_UP);
   endfunction

   // one character or end of text through the scan state
   task automatic scan_step(input logic [7:0] c, input logic eot);
      int d;
      logic [67:0] grown;
      if (scan_phase == ils_pkg::PH_DIGITS) begin
         if (eot) begin
            close_literal(ils_pkg::K_INT, 1'b0);
         end else begin
            d = digit_of(c, hex_digits);
            if (d >= 0) begin
               grown = 68'(acc_value) * (hex_digits ? 68'd16 : 68'd10) + 68'(d);
               if (grown > 68'(LONG_MASK)) begin
                  push_literal('0, ils_pkg::K_INT, ils_pkg::ST_DIGIT_OVF, 1'b0);
               end else begin
                  acc_value = grown[63:0];
                  if (d != 0) zeros_only = 1'b0;
               end
            end else if (zeros_only && !hex_digits &&
                         (c == ils_pkg::CH_X_LO || c == ils_pkg::CH_X_UP)) begin
               hex_digits = 1'b1;
               zeros_only = 1'b0;
            end else if (c == ils_pkg::CH_DOT ||
                         (!hex_digits && (c == ils_pkg::CH_E_LO || c == ils_pkg::CH_E_UP))) begin
               push_literal('0, ils_pkg::K_INT, ils_pkg::ST_FRACTIONAL, 1'b1);
            end else if (is_l(c)) begin
               close_literal(ils_pkg::K_LONG, 1'b1);
            end else if (c == ils_pkg::CH_U_LO || c == ils_pkg::CH_U_UP) begin
               scan_phase = ils_pkg::PH_USUF;
            end else begin
               close_literal(ils_pkg::K_INT, 1'b0);
            end
         end
      end else if (scan_phase == ils_pkg::PH_USUF) begin
         if (!eot && is_l(c)) close_literal(ils_pkg::K_ULONG, 1'b1);
         else close_literal(ils_pkg::K_UINT, 1'b0);
      end else begin
         // idle or sign seen
         if (eot) begin
            push_literal('0, ils_pkg::K_INT, ils_pkg::ST_NO_DIGIT, 1'b0);
         end else if (scan_phase != ils_pkg::PH_SIGN &&
                      (c == ils_pkg::CH_MINUS || c == ils_pkg::CH_PLUS)) begin
            minus_seen = (c == ils_pkg::CH_MINUS);
            scan_phase = ils_pkg::PH_SIGN;
         end else begin
            d = digit_of(c, 1'b0);
            if (d < 0) begin
               push_literal('0, ils_pkg::K_INT, ils_pkg::ST_NO_DIGIT, 1'b0);
            end else begin
               scan_phase = ils_pkg::PH_DIGITS;
               hex_digits = 1'b0;
               acc_value  = 64'(d);
               zeros_only = (d == 0);
            end
         end
      end
   endtask

   // results are checked before the character of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         clear_scan();
         literal_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (literal_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, '0);
            end else begin
               want = literal_q.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("value", rsp_tdata, want.value);
               if (rsp_tuser[1:0] !== want.kind)
                  report_mismatch("kind", 64'(rsp_tuser[1:0]), 64'(want.kind));
               if (rsp_tuser[4:2] !== want.status)
                  report_mismatch("status", 64'(rsp_tuser[4:2]), 64'(want.status));
               if (rsp_tuser[5] !== want.consumed)
                  report_mismatch("stop_consumed", 64'(rsp_tuser[5]), 64'(want.consumed));
               if (rsp_tuser[7:6] !== 2'b00)
                  report_mismatch("tuser padding", 64'(rsp_tuser[7:6]), '0);
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) scan_step(req_tdata, req_tlast);
      end
      pending_count <= literal_q.size();
      fail_count    <= mismatches;
   end

endmodule

FILE: tb/sv/integer_literal_scanner_tb.sv
`timescale 1ns / 100ps
// integer_literal_scanner_tb: clock, reset and stream stimulus for the scanner
// drives directed and random literals, gives the verdict from the checker's count
// depends on ils_pkg, integer_literal_scanner and integer_literal_scanner_checker
module integer_literal_scanner_tb;

   localparam int VALUE_WIDTH  = 64;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] ch
   logic        req_tlast = 1'b0; // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [63:0] value
   logic [7:0]  rsp_tuser;        // [1:0] kind, [4:2] status, [5] stop_consumed, [7:6] zero
   int          fail_count;
   int          pending;

   bit steady = 1'b0;   // no idling on either side while set
   int chars_sent = 0;
   int cycles = 0;

   integer_literal_scanner #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   integer_literal_scanner_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending_count(pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("integer_literal_scanner_tb failed");
         $finish;
      end
   end

   // one character transaction, after a random gap
   task automatic send_char(input logic [7:0] c, input logic eot);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // sign, decimal or hex digits, suffix and stop character with random content
   task automatic send_random_literal();
      string       text;
      string       body;
      string       stops;
      logic [63:0] v;
      logic [8:0]  stop_item;
      bit          hex;
      bit          ends_itself;
      text  = "";
      stops = " ,;)]\t";
      case ($urandom_range(0, 9))
         6, 7:    text = "-";
         8:       text = "+";
         9:       text = ($urandom_range(0, 1) != 0) ? "-+" : "--";
         default: text = "";
      endcase
      case ($urandom_range(0, 9))
         0:       v = 64'($urandom_range(0, 99));
         1:       v = 64'h7FFF_FFFF + 64'($urandom_range(0, 4)) - 64'd2;
         2:       v = 64'hFFFF_FFFF + 64'($urandom_range(0, 4)) - 64'd2;
         3:       v = 64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(0, 4)) - 64'd2;
         4:       v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         5:       v = {$urandom, $urandom};
         6:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
         default: v = 64'($urandom);
      endcase
      hex = ($urandom_range(0, 2) == 0);
      if (hex) begin
         body = $sformatf("%0h", v);
         for (int i = 0; i < body.len(); i++)
            if (body[i] >= "a" && body[i] <= "f" && $urandom_range(0, 1) != 0)
               body[i] = body[i] - 8'd32;
         // one more digit may overflow, no digit at all gives zero
         if ($urandom_range(0, 7) == 0) body = {body, $sformatf("%0h", $urandom_range(0, 15))};
         if ($urandom_range(0, 9) == 0) body = "";
         case ($urandom_range(0, 2))
            0:       text = {text, "0"};
            1:       text = {text, "00"};
            default: text = {text, "000"};
         endcase
         text = {text, ($urandom_range(0, 1) != 0) ? "x" : "X", body};
      end else begin
         body = $sformatf("%0d", v);
         // just under the accumulator limit, the next digit may or may not fit
         if ($urandom_range(0, 9) == 0)
            body = {"1844674407370955161", $sformatf("%0d", $urandom_range(0, 9))};
         else if ($urandom_range(0, 9) == 0)
            body = {body, $sformatf("%0d", $urandom_range(0, 99))};
         if ($urandom_range(0, 7) == 0) body = {"0", body};
         text = {text, body};
      end
      ends_itself = 1'b0;
      case ($urandom_range(0, 13))
         0: begin text = {text, "L"}; ends_itself = 1'b1; end
         1: begin text = {text, "l"}; ends_itself = 1'b1; end
         2: text = {text, "U"};
         3: text = {text, "u"};
         4: begin text = {text, "UL"}; ends_itself = 1'b1; end
         5: begin text = {text, "ul"}; ends_itself = 1'b1; end
         6: begin text = {text, "Ul"}; ends_itself = 1'b1; end
         7: begin text = {text, "uL"}; ends_itself = 1'b1; end
         8: begin text = {text, "."}; ends_itself = 1'b1; end
         9: begin text = {text, ($urandom_range(0, 1) != 0) ? "e" : "E"}; ends_itself = !hex; end
         default: ;
      endcase
      send_text(text);
      if (ends_itself && $urandom_range(0, 3) != 0) return;
      case ($urandom_range(0, 5))
         0, 1:    stop_item = {1'b1, 8'($urandom)};
         2:       stop_item = {1'b0, 8'($urandom)};
         default: stop_item = {1'b0, stops[$urandom_range(0, stops.len() - 1)]};
      endcase
      send_char(stop_item[7:0], stop_item[8]);
   endtask

   // result side: random stall before each result
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // stimulus and verdict
   initial begin
      bit drained_once;
      drained_once = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: end of text in idle with a full character byte
      send_char(8'hFF, 1'b1);
      // zero byte is no digit
      send_char(8'h00, 1'b0);
      // sign after sign
      send_text("+-");
      // negated int ended by end of text
      send_text("-5");
      send_char(8'h00, 1'b1);
      // zeros then x with no hex digit after it
      send_text("0x");
      send_char(8'h00, 1'b1);
      // fraction forms
      send_text("12.");
      send_text("1e");
      // suffixes: UL and L end at once, U alone on the next character
      send_text("7UL");
      send_text("3L");
      send_text("9U ");

      // random part: mostly literals, some raw noise
      chars_sent = 0;
      while (chars_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 11) == 0) steady = ~steady;
         if (!drained_once && chars_sent >= RANDOM_ITEMS / 2) begin
            // hold off until every result has come out
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
            repeat ($urandom_range(1, 5)) @(posedge clock);
            drained_once = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4))
               send_char(8'($urandom), ($urandom_range(0, 7) == 0));
         end else begin
            send_random_literal();
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("integer_literal_scanner_tb passed");
      else
         $display("integer_literal_scanner_tb failed");
      $finish;
   end

endmodule
